// File: hw/rtl/tcc_pkg.sv
// ----------------------------------------------------------------------------
// tcc_pkg
// shared constants, types and codes for the text console cursor block
// ----------------------------------------------------------------------------
`default_nettype none

package tcc_pkg;

  // screen geometry limits
  localparam int MAX_COLUMNS = 128;
  localparam int MAX_ROWS    = 64;
  localparam int TAB_MAX     = 16;

  // field widths
  localparam int COL_W     = $clog2(MAX_COLUMNS);          // column index
  localparam int COLS_W    = $clog2(MAX_COLUMNS + 1);      // column count
  localparam int ROW_W     = $clog2(MAX_ROWS);             // row index
  localparam int ROWS_W    = $clog2(MAX_ROWS + 1);         // row count
  localparam int PHASE_W   = $clog2(TAB_MAX);              // tab phase
  localparam int TW_W      = $clog2(TAB_MAX + 1);          // tab width
  localparam int TAB_SUM_W = $clog2(MAX_COLUMNS + TAB_MAX); // column plus tab step
  localparam int CHAR_W    = 8;
  localparam int CFG_W     = 8;
  localparam int CFG_IDX_W = 2;

  // raw register widths
  localparam int COLS_REG_W = 8;
  localparam int ROWS_REG_W = 7;
  localparam int TW_REG_W   = 5;

  // register reset values
  localparam int COLS_RESET = 30;
  localparam int ROWS_RESET = 40;
  localparam int TW_RESET   = 4;

  typedef logic [COL_W-1:0]     col_t;
  typedef logic [COLS_W-1:0]    cols_t;
  typedef logic [ROW_W-1:0]     row_t;
  typedef logic [ROWS_W-1:0]    rows_t;
  typedef logic [PHASE_W-1:0]   phase_t;
  typedef logic [TW_W-1:0]      tw_t;
  typedef logic [TAB_SUM_W-1:0] tab_sum_t;
  typedef logic [CHAR_W-1:0]    char_t;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TEXT_COLUMNS = 2'd0,
    CFG_TEXT_ROWS    = 2'd1,
    CFG_TAB_WIDTH    = 2'd2,
    CFG_UNUSED       = 2'd3
  } cfg_idx_e;

  // character codes
  localparam char_t CHAR_PRINT_MIN = 8'd32;
  localparam char_t CHAR_SPACE     = 8'd32;
  localparam char_t CHAR_BS        = 8'd8;
  localparam char_t CHAR_HT        = 8'd9;
  localparam char_t CHAR_LF        = 8'd10;
  localparam char_t CHAR_VT        = 8'd11;
  localparam char_t CHAR_FF        = 8'd12;
  localparam char_t CHAR_CR        = 8'd13;

  // cursor state
  typedef struct packed {
    row_t   row;
    col_t   col;
    phase_t phase;
  } cursor_t;

  // effective (clamped) geometry
  typedef struct packed {
    cols_t cols;
    rows_t rows;
    tw_t   tw;
  } geom_t;

  // one result item
  typedef struct packed {
    logic  write_valid;
    char_t glyph_code;
    row_t  glyph_row;
    col_t  glyph_col;
    row_t  cursor_row;
    col_t  cursor_col;
  } result_t;

endpackage

`default_nettype wire

// File: hw/rtl/tcc_step.sv
// ----------------------------------------------------------------------------
// tcc_step
// cursor update and glyph write decode for one character
// ----------------------------------------------------------------------------
`default_nettype none

module tcc_step (
  input  var tcc_pkg::cursor_t cur_i,
  input  var tcc_pkg::geom_t   geom_i,
  input  var tcc_pkg::char_t   char_code_i,
  output tcc_pkg::cursor_t     nxt_o,
  output tcc_pkg::result_t     res_o
);

  tcc_pkg::cursor_t  fix;
  tcc_pkg::rows_t    row_n;
  tcc_pkg::col_t     col_n;
  tcc_pkg::phase_t   phase_n;
  tcc_pkg::cols_t    col_inc;
  tcc_pkg::tw_t      phase_inc;
  tcc_pkg::rows_t    row_inc;
  tcc_pkg::tw_t      tab_step;
  tcc_pkg::tab_sum_t tab_col;
  logic              wv;
  tcc_pkg::char_t    gcode;
  tcc_pkg::col_t     gcol;

  // bring the cursor back inside the current geometry
  always_comb begin
    fix = cur_i;
    if (tcc_pkg::cols_t'(cur_i.col) >= geom_i.cols ||
        tcc_pkg::tw_t'(cur_i.phase) >= geom_i.tw) begin
      fix.col   = '0;
      fix.phase = '0;
    end
    if (tcc_pkg::rows_t'(cur_i.row) >= geom_i.rows) begin
      fix = '0;
    end
  end

  assign col_inc   = tcc_pkg::cols_t'(fix.col) + tcc_pkg::cols_t'(1);
  assign phase_inc = tcc_pkg::tw_t'(fix.phase) + tcc_pkg::tw_t'(1);
  assign row_inc   = tcc_pkg::rows_t'(fix.row) + tcc_pkg::rows_t'(1);
  assign tab_step  = geom_i.tw - tcc_pkg::tw_t'(fix.phase);
  assign tab_col   = tcc_pkg::tab_sum_t'(fix.col) + tcc_pkg::tab_sum_t'(tab_step);

  always_comb begin
    row_n   = tcc_pkg::rows_t'(fix.row);
    col_n   = fix.col;
    phase_n = fix.phase;
    wv      = 1'b0;
    gcode   = '0;
    gcol    = '0;
    if (char_code_i >= tcc_pkg::CHAR_PRINT_MIN) begin
      wv      = 1'b1;
      gcode   = char_code_i;
      gcol    = fix.col;
      col_n   = tcc_pkg::col_t'(col_inc);
      phase_n = (phase_inc >= geom_i.tw) ? '0 : tcc_pkg::phase_t'(phase_inc);
      if (col_inc >= geom_i.cols) begin
        col_n   = '0;
        phase_n = '0;
        row_n   = row_inc;
      end
    end else begin
      unique case (char_code_i)
        tcc_pkg::CHAR_BS: begin
          if (fix.col != '0) begin
            col_n   = fix.col - tcc_pkg::col_t'(1);
            phase_n = (fix.phase == '0) ? tcc_pkg::phase_t'(geom_i.tw - tcc_pkg::tw_t'(1))
                                        : fix.phase - tcc_pkg::phase_t'(1);
            wv      = 1'b1;
            gcode   = tcc_pkg::CHAR_SPACE;
            gcol    = col_n;
          end
        end
        tcc_pkg::CHAR_FF: begin
          row_n   = '0;
          col_n   = '0;
          phase_n = '0;
        end
        tcc_pkg::CHAR_LF: begin
          row_n   = row_inc;
          col_n   = '0;
          phase_n = '0;
        end
        tcc_pkg::CHAR_CR: begin
          col_n   = '0;
          phase_n = '0;
        end
        tcc_pkg::CHAR_HT: begin
          if (tab_col >= tcc_pkg::tab_sum_t'(geom_i.cols)) begin
            row_n = row_inc;
            col_n = '0;
          end else begin
            col_n = tcc_pkg::col_t'(tab_col);
          end
          phase_n = '0;
        end
        tcc_pkg::CHAR_VT: begin
          row_n = row_inc;
        end
        default: begin
          // other control codes leave the cursor alone
        end
      endcase
    end
  end

  // wrap past the last row to home
  always_comb begin
    if (row_n >= geom_i.rows) begin
      nxt_o = '0;
    end else begin
      nxt_o.row   = tcc_pkg::row_t'(row_n);
      nxt_o.col   = col_n;
      nxt_o.phase = phase_n;
    end
  end

  always_comb begin
    res_o.write_valid = wv;
    res_o.glyph_code  = gcode;
    res_o.glyph_row   = wv ? fix.row : '0;
    res_o.glyph_col   = gcol;
    res_o.cursor_row  = nxt_o.row;
    res_o.cursor_col  = nxt_o.col;
  end

endmodule

`default_nettype wire

// File: hw/rtl/text_console_cursor.sv
// ----------------------------------------------------------------------------
// text_console_cursor
// text terminal cursor control: character stream to glyph cell writes
// ----------------------------------------------------------------------------
// Takes one character code per transaction and returns exactly one result
// transaction with the glyph write (if any) and the cursor position after the
// character. The block sustains one transaction per clock cycle while its
// results are taken: the whole cursor update is a handful of compares and
// increments on small counters, done in one pass between the cursor
// and result registers, so a result appears the cycle after its character.
// The result register decouples the two sides: a new character is taken
// whenever the result register is empty or its contents are taken in the
// same cycle. Geometry registers are clamped when written (zero acts as one,
// large values saturate), and any write to a known register homes the
// cursor. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_cursor (
  input  var logic                           clk_i,
  input  var logic                           rst_ni,
  // configuration write port
  input  var logic                           cfg_we_i,
  input  var logic [tcc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  var logic [tcc_pkg::CFG_W-1:0]      cfg_data_i,
  // character input
  input  var logic                           in_valid_i,
  output logic                               in_ready_o,
  input  var logic [7:0]                     char_code_i,
  // result output
  output logic                               out_valid_o,
  input  var logic                           out_ready_i,
  output logic                               write_valid_o,
  output logic [7:0]                         glyph_code_o,
  output logic [5:0]                         glyph_row_o,
  output logic [6:0]                         glyph_col_o,
  output logic [5:0]                         cursor_row_out_o,
  output logic [6:0]                         cursor_col_out_o
);

  // clamp helpers: zero acts as one, large values saturate
  function automatic tcc_pkg::cols_t clamp_cols(
    input logic [tcc_pkg::COLS_REG_W-1:0] v
  );
    tcc_pkg::cols_t r;
    if (v == '0) begin
      r = tcc_pkg::cols_t'(1);
    end else if (int'(v) > tcc_pkg::MAX_COLUMNS) begin
      r = tcc_pkg::cols_t'(tcc_pkg::MAX_COLUMNS);
    end else begin
      r = tcc_pkg::cols_t'(v);
    end
    return r;
  endfunction

  function automatic tcc_pkg::rows_t clamp_rows(
    input logic [tcc_pkg::ROWS_REG_W-1:0] v
  );
    tcc_pkg::rows_t r;
    if (v == '0) begin
      r = tcc_pkg::rows_t'(1);
    end else if (int'(v) > tcc_pkg::MAX_ROWS) begin
      r = tcc_pkg::rows_t'(tcc_pkg::MAX_ROWS);
    end else begin
      r = tcc_pkg::rows_t'(v);
    end
    return r;
  endfunction

  function automatic tcc_pkg::tw_t clamp_tw(
    input logic [tcc_pkg::TW_REG_W-1:0] v
  );
    tcc_pkg::tw_t r;
    if (v == '0) begin
      r = tcc_pkg::tw_t'(1);
    end else if (int'(v) > tcc_pkg::TAB_MAX) begin
      r = tcc_pkg::tw_t'(tcc_pkg::TAB_MAX);
    end else begin
      r = tcc_pkg::tw_t'(v);
    end
    return r;
  endfunction

  tcc_pkg::geom_t   geom_q, geom_d;
  tcc_pkg::cursor_t cur_q, cur_d;
  tcc_pkg::cursor_t cur_nxt;
  tcc_pkg::result_t res_q, res_d;
  tcc_pkg::result_t res_nxt;
  logic             out_valid_q, out_valid_d;
  logic             in_fire;
  logic             cfg_hit;
  tcc_pkg::cfg_idx_e cfg_idx;

  assign cfg_idx = tcc_pkg::cfg_idx_e'(cfg_idx_i);

  // output register free or being drained this cycle
  assign in_ready_o = ~out_valid_q | out_ready_i;
  assign in_fire    = in_valid_i & in_ready_o;

  // per-character cursor logic
  tcc_step u_step (
    .cur_i       (cur_q),
    .geom_i      (geom_q),
    .char_code_i (char_code_i),
    .nxt_o       (cur_nxt),
    .res_o       (res_nxt)
  );

  // geometry registers, stored already clamped
  always_comb begin
    geom_d  = geom_q;
    cfg_hit = 1'b0;
    if (cfg_we_i) begin
      unique case (cfg_idx)
        tcc_pkg::CFG_TEXT_COLUMNS: begin
          geom_d.cols = clamp_cols(cfg_data_i[tcc_pkg::COLS_REG_W-1:0]);
          cfg_hit     = 1'b1;
        end
        tcc_pkg::CFG_TEXT_ROWS: begin
          geom_d.rows = clamp_rows(cfg_data_i[tcc_pkg::ROWS_REG_W-1:0]);
          cfg_hit     = 1'b1;
        end
        tcc_pkg::CFG_TAB_WIDTH: begin
          geom_d.tw = clamp_tw(cfg_data_i[tcc_pkg::TW_REG_W-1:0]);
          cfg_hit   = 1'b1;
        end
        default: begin
          // unknown index: write dropped, cursor kept
        end
      endcase
    end
  end

  // cursor: a known register write homes it, otherwise it follows each character
  always_comb begin
    priority if (cfg_hit) begin
      cur_d = '0;
    end else if (in_fire) begin
      cur_d = cur_nxt;
    end else begin
      cur_d = cur_q;
    end
  end

  // result register and its valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    res_d       = res_q;
    if (in_fire) begin
      out_valid_d = 1'b1;
      res_d       = res_nxt;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      geom_q.cols <= tcc_pkg::cols_t'(tcc_pkg::COLS_RESET);
      geom_q.rows <= tcc_pkg::rows_t'(tcc_pkg::ROWS_RESET);
      geom_q.tw   <= tcc_pkg::tw_t'(tcc_pkg::TW_RESET);
      cur_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      geom_q      <= geom_d;
      cur_q       <= cur_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload only, no reset needed
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_valid_o      = out_valid_q;
  assign write_valid_o    = res_q.write_valid;
  assign glyph_code_o     = res_q.glyph_code;
  assign glyph_row_o      = res_q.glyph_row;
  assign glyph_col_o      = res_q.glyph_col;
  assign cursor_row_out_o = res_q.cursor_row;
  assign cursor_col_out_o = res_q.cursor_col;

endmodule

`default_nettype wire

// File: tb/sv/tb_text_console_cursor.sv
// ----------------------------------------------------------------------------
// tb_text_console_cursor
// self-checking testbench for the text console cursor block
// ----------------------------------------------------------------------------
// Streams character codes into the block and checks every result transaction
// against a cycle-free predictor of the cursor, held in the testbench with its
// own copy of the geometry registers. The named tests cover the extremes of
// the character byte, every control code, tabs that run past the line end,
// wrap to home, register clamping and writes to the unused register index.
// A long random run follows under changing geometry. Both handshakes see
// random gaps and stalls.
// ----------------------------------------------------------------------------

module tb_text_console_cursor;
  timeunit 1ns;
  timeprecision 1ps;

  import tcc_pkg::*;

  // cycles without any accepted transaction before the run is abandoned
  localparam int STALL_LIMIT = 2000;

  // clock, reset and block inputs, all known from time zero
  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i   = '0;
  logic [CFG_W-1:0]     cfg_data_i  = '0;
  logic                 in_valid_i  = 1'b0;
  logic [7:0]           char_code_i = '0;
  logic                 out_ready_i = 1'b0;

  // block outputs
  logic       in_ready_o;
  logic       out_valid_o;
  logic       write_valid_o;
  logic [7:0] glyph_code_o;
  logic [5:0] glyph_row_o;
  logic [6:0] glyph_col_o;
  logic [5:0] cursor_row_out_o;
  logic [6:0] cursor_col_out_o;

  // predictor state: raw register contents and the cursor
  logic [7:0] cols_reg = 8'(COLS_RESET);
  logic [6:0] rows_reg = 7'(ROWS_RESET);
  logic [4:0] tw_reg   = 5'(TW_RESET);
  int         cur_row   = 0;
  int         cur_col   = 0;
  int         cur_phase = 0;

  // cursor moves still owed by the block, oldest first
  result_t predicted_moves[$];

  int error_count = 0;
  int stall_left  = 0;
  bit quiet_mode  = 1'b0;   // no gaps and no stalls while set

  text_console_cursor dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .char_code_i      (char_code_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .write_valid_o    (write_valid_o),
    .glyph_code_o     (glyph_code_o),
    .glyph_row_o      (glyph_row_o),
    .glyph_col_o      (glyph_col_o),
    .cursor_row_out_o (cursor_row_out_o),
    .cursor_col_out_o (cursor_col_out_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ------------------------------------------------------------------------
  // predictor
  // ------------------------------------------------------------------------

  // zero acts as one, anything above the limit saturates
  function automatic int effective(input int raw, input int limit);
    if (raw == 0) return 1;
    if (raw > limit) return limit;
    return raw;
  endfunction

  function automatic void home_cursor();
    cur_row   = 0;
    cur_col   = 0;
    cur_phase = 0;
  endfunction

  // moves the predicted cursor for one character and returns the result
  function automatic result_t advance_cursor(input char_t c);
    int      cols;
    int      rows;
    int      tw;
    int      next_col;
    result_t r;
    cols = effective(int'(cols_reg), MAX_COLUMNS);
    rows = effective(int'(rows_reg), MAX_ROWS);
    tw   = effective(int'(tw_reg), TAB_MAX);
    r    = '0;

    // pull the cursor back inside the current geometry
    if (cur_col >= cols || cur_phase >= tw) begin
      cur_col   = 0;
      cur_phase = 0;
    end
    if (cur_row >= rows) home_cursor();

    if (c >= CHAR_PRINT_MIN) begin
      // glyph at the cursor, then step right with line wrap
      r.write_valid = 1'b1;
      r.glyph_code  = c;
      r.glyph_row   = cur_row[5:0];
      r.glyph_col   = cur_col[6:0];
      cur_col++;
      cur_phase = (cur_phase + 1 >= tw) ? 0 : cur_phase + 1;
      if (cur_col >= cols) begin
        cur_col   = 0;
        cur_phase = 0;
        cur_row++;
      end
    end else begin
      case (c)
        CHAR_BS: begin
          // erase to the left; nothing happens at column zero
          if (cur_col > 0) begin
            cur_col--;
            cur_phase     = (cur_phase == 0) ? tw - 1 : cur_phase - 1;
            r.write_valid = 1'b1;
            r.glyph_code  = CHAR_SPACE;
            r.glyph_row   = cur_row[5:0];
            r.glyph_col   = cur_col[6:0];
          end
        end
        CHAR_FF: home_cursor();
        CHAR_LF: begin
          cur_row++;
          cur_col   = 0;
          cur_phase = 0;
        end
        CHAR_CR: begin
          cur_col   = 0;
          cur_phase = 0;
        end
        CHAR_HT: begin
          // next tab stop, or the start of the next row if it is off the line
          next_col = cur_col + (tw - cur_phase);
          if (next_col >= cols) begin
            cur_row++;
            cur_col = 0;
          end else begin
            cur_col = next_col;
          end
          cur_phase = 0;
        end
        CHAR_VT: cur_row++;
        default: ;   // other control codes leave the cursor alone
      endcase
    end

    // past the last row wraps to home
    if (cur_row >= rows) home_cursor();

    r.cursor_row = cur_row[5:0];
    r.cursor_col = cur_col[6:0];
    return r;
  endfunction

  // ------------------------------------------------------------------------
  // shared tasks
  // ------------------------------------------------------------------------

  task automatic flag_error(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  // gap length: mostly none, some short, a few long
  function automatic int gap_cycles();
    int sel;
    sel = $urandom_range(0, 99);
    if (quiet_mode || sel < 60) return 0;
    if (sel < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // one character transaction; valid is left high so that a back-to-back
  // transaction keeps it up, and drain_results lowers it
  task automatic send_char(input char_t c);
    int gap;
    gap = gap_cycles();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    char_code_i <= c;
    do @(posedge clk_i); while (!in_ready_o);
    predicted_moves.push_back(advance_cursor(c));
  endtask

  // sender pauses until every owed result has come back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (predicted_moves.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  // register write, only ever issued with the block idle
  task automatic write_reg(input cfg_idx_e idx, input logic [7:0] value);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      CFG_TEXT_COLUMNS: cols_reg = value;
      CFG_TEXT_ROWS:    rows_reg = value[6:0];
      CFG_TAB_WIDTH:    tw_reg   = value[4:0];
      default: ;
    endcase
    // a known register homes the cursor, the unused index does nothing
    if (idx != CFG_UNUSED) home_cursor();
  endtask

  // ------------------------------------------------------------------------
  // result side: stalls and checking
  // ------------------------------------------------------------------------

  always @(posedge clk_i) begin
    if (quiet_mode) begin
      out_ready_i <= 1'b1;
    end else if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left--;
    end else if ($urandom_range(0, 99) < 20) begin
      out_ready_i <= 1'b0;
      stall_left = gap_cycles();
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // compare each accepted result transaction with the oldest prediction
  always @(posedge clk_i) begin : check_results
    result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (predicted_moves.size() == 0) begin
        flag_error("result transaction with no character pending");
      end else begin
        want = predicted_moves.pop_front();
        if (write_valid_o !== want.write_valid)
          flag_error($sformatf("write_valid %0b, want %0b", write_valid_o, want.write_valid));
        if (glyph_code_o !== want.glyph_code)
          flag_error($sformatf("glyph_code %0d, want %0d", glyph_code_o, want.glyph_code));
        if (glyph_row_o !== want.glyph_row)
          flag_error($sformatf("glyph_row %0d, want %0d", glyph_row_o, want.glyph_row));
        if (glyph_col_o !== want.glyph_col)
          flag_error($sformatf("glyph_col %0d, want %0d", glyph_col_o, want.glyph_col));
        if (cursor_row_out_o !== want.cursor_row)
          flag_error($sformatf("cursor_row %0d, want %0d", cursor_row_out_o,
                               want.cursor_row));
        if (cursor_col_out_o !== want.cursor_col)
          flag_error($sformatf("cursor_col %0d, want %0d", cursor_col_out_o,
                               want.cursor_col));
      end
    end
  end

  // watchdog: any cycle without a transaction on either side counts
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("tb_text_console_cursor: errors");
    $finish;
  end

  // ------------------------------------------------------------------------
  // tests
  // ------------------------------------------------------------------------

  // lowest, highest and a few middle printable codes at reset geometry
  task automatic test_printable_extremes();
    send_char(CHAR_PRINT_MIN);
    send_char(8'd126);
    send_char(8'd255);
    send_char(8'd127);
    drain_results();
  endtask

  // every control code, backspace at column zero and ignored codes
  task automatic test_control_codes();
    send_char(CHAR_BS);         // erase one cell back
    send_char(CHAR_CR);
    send_char(CHAR_BS);         // at column zero: no write, no move
    send_char(CHAR_HT);
    send_char(CHAR_HT);
    send_char(CHAR_VT);         // row advances, column kept
    send_char(CHAR_LF);
    send_char(8'd0);            // ignored control codes
    send_char(8'd31);
    send_char(8'd7);
    send_char(CHAR_FF);
    drain_results();
  endtask

  // tab landing exactly on the line end, and a tab wider than the line
  task automatic test_tab_past_line_end();
    write_reg(CFG_TEXT_COLUMNS, 8'd8);
    send_char(8'h41);
    send_char(CHAR_HT);         // to column 4
    send_char(CHAR_HT);         // stop at 8 is the line end: next row
    drain_results();
    write_reg(CFG_TEXT_COLUMNS, 8'd5);
    write_reg(CFG_TAB_WIDTH, 8'd16);
    send_char(CHAR_HT);         // always the next row
    drain_results();
  endtask

  // running off the last cell and off the last row both go home
  task automatic test_wrap_to_home();
    write_reg(CFG_TEXT_COLUMNS, 8'd2);
    write_reg(CFG_TEXT_ROWS, 8'd2);
    write_reg(CFG_TAB_WIDTH, 8'd1);
    repeat (4) send_char(8'h5a);
    send_char(CHAR_LF);
    send_char(CHAR_LF);
    drain_results();
  endtask

  // zero registers act as one, oversized ones saturate
  task automatic test_register_limits();
    write_reg(CFG_TEXT_COLUMNS, 8'd0);
    write_reg(CFG_TEXT_ROWS, 8'd0);
    write_reg(CFG_TAB_WIDTH, 8'd0);
    send_char(8'h61);
    send_char(CHAR_HT);
    send_char(CHAR_BS);
    drain_results();
    write_reg(CFG_TEXT_COLUMNS, 8'hff);
    write_reg(CFG_TEXT_ROWS, 8'hff);
    write_reg(CFG_TAB_WIDTH, 8'hff);
    send_char(CHAR_HT);
    send_char(CHAR_HT);
    send_char(8'h7a);
    drain_results();
  endtask

  // a write to the unused index must not home the cursor
  task automatic test_unknown_register();
    send_char(8'h62);
    drain_results();
    write_reg(CFG_UNUSED, 8'hff);
    send_char(8'h63);
    drain_results();
    write_reg(CFG_UNUSED, 8'h00);
    send_char(CHAR_BS);
    drain_results();
  endtask

  // random text over many geometries, small screens most of the time so
  // that line wrap, row wrap and tabs past the end come up often
  task automatic test_random_text();
    int    n;
    int    sel;
    bit    lf_heavy;
    char_t c;
    for (int p = 0; p < 20; p++) begin
      drain_results();
      quiet_mode = ($urandom_range(0, 4) == 0);
      lf_heavy   = ($urandom_range(0, 3) == 0);

      // new geometry, registers in no fixed pattern
      if ($urandom_range(0, 4) != 0) begin
        sel = $urandom_range(0, 99);
        if (sel < 60)      write_reg(CFG_TEXT_COLUMNS, 8'($urandom_range(1, 10)));
        else if (sel < 75) write_reg(CFG_TEXT_COLUMNS, 8'($urandom_range(11, 40)));
        else if (sel < 85) write_reg(CFG_TEXT_COLUMNS, 8'(MAX_COLUMNS));
        else               write_reg(CFG_TEXT_COLUMNS, 8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 4) != 0) begin
        sel = $urandom_range(0, 99);
        if (sel < 60)      write_reg(CFG_TEXT_ROWS, 8'($urandom_range(1, 4)));
        else if (sel < 75) write_reg(CFG_TEXT_ROWS, 8'($urandom_range(5, 20)));
        else if (sel < 85) write_reg(CFG_TEXT_ROWS, 8'(MAX_ROWS));
        else               write_reg(CFG_TEXT_ROWS, 8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 4) != 0) begin
        sel = $urandom_range(0, 99);
        if (sel < 70)      write_reg(CFG_TAB_WIDTH, 8'($urandom_range(1, 16)));
        else if (sel < 80) write_reg(CFG_TAB_WIDTH, 8'd1);
        else if (sel < 90) write_reg(CFG_TAB_WIDTH, 8'(TAB_MAX));
        else               write_reg(CFG_TAB_WIDTH, 8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 4) == 0) write_reg(CFG_UNUSED, 8'($urandom_range(0, 255)));

      n = $urandom_range(40, 70);
      for (int i = 0; i < n; i++) begin
        sel = $urandom_range(0, 99);
        if (sel < (lf_heavy ? 30 : 50)) begin
          c = 8'($urandom_range(32, 255));
        end else if (sel < 85) begin
          // cursor movers, newline and vertical tab favoured in lf_heavy passes
          case ($urandom_range(0, lf_heavy ? 7 : 5))
            0:       c = CHAR_BS;
            1:       c = CHAR_HT;
            2:       c = CHAR_CR;
            3:       c = CHAR_FF;
            4, 6:    c = CHAR_LF;
            default: c = CHAR_VT;
          endcase
          // form feed kept rare so the cursor can get somewhere
          if (c == CHAR_FF && $urandom_range(0, 3) != 0) c = CHAR_LF;
        end else if (sel < 93) begin
          c = 8'($urandom_range(0, 31));
        end else begin
          c = 8'($urandom_range(0, 255));
        end
        send_char(c);
        // occasional hold-off mid-stream until the block has caught up
        if (i == n / 2 && $urandom_range(0, 2) == 0) drain_results();
      end
    end
  endtask

  // ------------------------------------------------------------------------
  // sequence
  // ------------------------------------------------------------------------

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    test_printable_extremes();
    test_control_codes();
    test_tab_past_line_end();
    test_wrap_to_home();
    test_register_limits();
    test_unknown_register();
    test_random_text();

    // let the pipe empty, then a few cycles for anything stray
    drain_results();
    repeat (4) @(posedge clk_i);
    if (predicted_moves.size() != 0)
      flag_error($sformatf("%0d results never arrived", predicted_moves.size()));

    if (error_count == 0) begin
      $display("tb_text_console_cursor: clean");
    end else begin
      $display("tb_text_console_cursor: errors");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/tcc_pkg.sv
hw/rtl/tcc_step.sv
hw/rtl/text_console_cursor.sv
tb/sv/tb_text_console_cursor.sv
